FILE: hdl/nsr_pkg.sv
// Shared constants and controller/datapath interface types for the Newton square root.
package nsr_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned MAX_ITERS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam logic [WORD_W-1:0] TOL_RESET = WORD_W'(655);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_x;      // capture radicand, seed guess with 1.0
    logic sq_en;       // register guess squared
    logic err_en;      // register |guess^2 - x|
    logic div_start;   // launch x / guess
    logic upd_g;       // guess <= (quotient + guess) / 2
    logic out_load;    // load the output register
    logic out_last;
    logic out_hit;
  } nsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tol_met;     // error below tolerance
    logic div_busy;
  } nsr_sts_t;

endpackage

FILE: hdl/nsr_div.sv
// Radix-2 restoring divider for (x << FRAC_BITS) / guess with saturation to 32 bits.
module nsr_div
  import nsr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [WORD_W+FRAC_BITS-1:0] dividend_i,
  input  logic [WORD_W-1:0]           divisor_i,
  output logic                        busy_o,
  output logic [WORD_W-1:0]           quotient_o
);

  localparam int unsigned XW = WORD_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(XW + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [XW-1:0]     dvd_q, dvd_d;
  logic [WORD_W:0]   trial;
  logic              take;

  // A zero divisor makes every trial subtract succeed, so the quotient
  // comes out all ones and saturates below.
  always_comb begin
    trial = {rem_q, dvd_q[XW-1]};
    take  = trial >= {1'b0, divisor_i};
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (start_i) begin
      cnt_d = CW'(XW);
      rem_d = '0;
      dvd_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
      rem_d = take ? WORD_W'(trial - {1'b0, divisor_i}) : trial[WORD_W-1:0];
      dvd_d = {dvd_q[XW-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = (|dvd_q[XW-1:WORD_W]) ? '1 : dvd_q[WORD_W-1:0];

endmodule

FILE: hdl/nsr_datapath.sv
// Datapath: radicand, guess, square, error, tolerance, divider and output register.
module nsr_datapath
  import nsr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nsr_cmd_t          cmd_i,
  output nsr_sts_t          sts_o,
  input  logic              cfg_we_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  input  logic [WORD_W-1:0] radicand_i,
  output logic [WORD_W-1:0] guess_o,
  output logic              last_o,
  output logic              hit_limit_o
);

  localparam int unsigned XW = WORD_W + FRAC_BITS;
  localparam int unsigned SW = 2 * WORD_W;
  localparam logic [WORD_W-1:0] GUESS_ONE = WORD_W'(1) << FRAC_BITS;

  logic [WORD_W-1:0] tol_q;
  logic [WORD_W-1:0] x_q, g_q, g_d;
  logic [SW-1:0]     sq_q, err_q, err_d;
  logic [XW-1:0]     xs, ts;
  logic [SW-1:0]     xs_w, ts_w;
  logic [WORD_W-1:0] quot;
  logic [WORD_W:0]   sum;
  logic              div_busy;
  logic [WORD_W-1:0] guess_q;
  logic              last_q, hit_q;

  nsr_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(xs),
    .divisor_i (g_q),
    .busy_o    (div_busy),
    .quotient_o(quot)
  );

  // Error is compared at 2*FRAC_BITS fraction bits, so x and tolerance move up.
  assign xs   = {x_q, {FRAC_BITS{1'b0}}};
  assign ts   = {tol_q, {FRAC_BITS{1'b0}}};
  assign xs_w = SW'(xs);
  assign ts_w = SW'(ts);

  assign err_d = (sq_q >= xs_w) ? (sq_q - xs_w) : (xs_w - sq_q);
  assign sum   = {1'b0, quot} + {1'b0, g_q};

  always_comb begin
    g_d = g_q;
    if (cmd_i.load_x) begin
      g_d = GUESS_ONE;
    end else if (cmd_i.upd_g) begin
      g_d = sum[WORD_W:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q <= g_d;
    if (cmd_i.load_x) begin
      x_q <= radicand_i;
    end
    if (cmd_i.sq_en) begin
      sq_q <= SW'(g_q) * SW'(g_q);
    end
    if (cmd_i.err_en) begin
      err_q <= err_d;
    end
    if (cmd_i.out_load) begin
      guess_q <= g_q;
      last_q  <= cmd_i.out_last;
      hit_q   <= cmd_i.out_hit;
    end
  end

  assign sts_o.tol_met  = err_q < ts_w;
  assign sts_o.div_busy = div_busy;

  assign guess_o     = guess_q;
  assign last_o      = last_q;
  assign hit_limit_o = hit_q;

endmodule

FILE: hdl/nsr_ctrl.sv
// Controller: sequences square, error check, output, division and update per Newton step.
module nsr_ctrl
  import nsr_pkg::*;
#(
  parameter int unsigned MAX_ITERS = MAX_ITERS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output nsr_cmd_t cmd_o,
  input  nsr_sts_t sts_i
);

  localparam int unsigned IW = $clog2(MAX_ITERS + 1);
  localparam logic [IW-1:0] ITER_CAP = IW'(MAX_ITERS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ERR,
    ST_DECIDE,
    ST_DIVIDE,
    ST_UPDATE
  } state_e;

  state_e        state_q;
  logic [IW-1:0] iter_q;
  logic          out_valid_q;
  logic          out_free;
  logic          done;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = state_q == ST_IDLE;
    out_free   = !out_valid_q || out_ready_i;
    done       = sts_i.tol_met || (iter_q == ITER_CAP);
    case (state_q)
      ST_IDLE:   cmd_o.load_x = in_valid_i;
      ST_SQUARE: cmd_o.sq_en  = 1'b1;
      ST_ERR:    cmd_o.err_en = 1'b1;
      ST_DECIDE: begin
        if (out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_last  = done;
          cmd_o.out_hit   = done && !sts_i.tol_met;
          cmd_o.div_start = !done;
        end
      end
      ST_DIVIDE: ;
      ST_UPDATE: cmd_o.upd_g = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            iter_q  <= '0;
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: state_q <= ST_ERR;
        ST_ERR:    state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (out_free) begin
            state_q <= done ? ST_IDLE : ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (!sts_i.div_busy) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          iter_q  <= iter_q + IW'(1);
          state_q <= ST_SQUARE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/newton_square_root_top.sv
// Newton-Raphson square root of an unsigned fixed-point value, one result per estimate.
//
// Each radicand (unsigned Q(32-FRAC_BITS).FRAC_BITS, Q16.16 by default)
// starts from a guess of 1.0 that is refined by
// guess = floor((floor(x/guess) + guess) / 2). Before every update the
// error |guess^2 - x| is checked at full precision; once it is strictly
// below the tolerance register, or after MAX_ITERS updates, the block
// stops. Every estimate, the initial 1.0 included, is sent as one output
// item; the final one carries last_o, and hit_limit_o is set on it when the
// cap was reached without meeting the tolerance. A zero guess or a quotient
// above 32 bits saturates the quotient to all ones. A step runs the square,
// the error check and the decision, which an output stall holds, then the
// radix-2 divider (one quotient bit per cycle) and the update. One item is
// worked on at a time; in_ready_o is high only while the controller is
// idle, and a new item may be taken while the final result of the previous
// one still waits in the output register. The tolerance (reset 655, about
// 0.01 at Q16.16) is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while the block is idle, as the block itself does not
// enforce this.
module newton_square_root_top
  import nsr_pkg::*;
#(
  parameter int unsigned MAX_ITERS = MAX_ITERS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // tolerance register write
  input  logic              cfg_we_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  // radicand items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WORD_W-1:0] radicand_i,
  // estimate items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] guess_o,
  output logic              last_o,
  output logic              hit_limit_o
);

  nsr_cmd_t cmd;
  nsr_sts_t sts;

  // Controller: walks square -> error -> decide -> divide -> update per step.
  nsr_ctrl #(
    .MAX_ITERS(MAX_ITERS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .cmd_o(cmd),
    .sts_i(sts)
  );

  // Datapath: one 32x32 multiplier, error subtract, serial divider.
  nsr_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i(cmd),
    .sts_o(sts),
    .cfg_we_i,
    .cfg_wdata_i,
    .radicand_i,
    .guess_o,
    .last_o,
    .hit_limit_o
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for newton_square_root_top: directed table, then random radicands.
module tb_top;
  import nsr_pkg::*;

  localparam int unsigned FRAC          = FRAC_BITS_DEF;
  localparam int unsigned ITERS         = MAX_ITERS_DEF;
  // Longest quiet stretch of a correct run is the long receiver hold
  // (HOLD_CYCLES). Allow a wide margin on top.
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 120;
  localparam logic [WORD_W-1:0] ONE_Q    = WORD_W'(1) << FRAC;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  // One estimate leaving the block.
  typedef struct packed {
    logic [WORD_W-1:0] guess;
    logic              last;
    logic              hit;
  } estimate_t;

  // Directed row: tolerance to run under, radicand, and a typed-in
  // single-result expectation when known is set.
  typedef struct packed {
    logic [WORD_W-1:0] tol;
    logic [WORD_W-1:0] radicand;
    logic              known;
    logic [WORD_W-1:0] guess;
    logic              last;
    logic              hit;
  } drow_t;

  localparam drow_t DIRECTED [18] = '{
    // exact root of 1.0 at reset tolerance: stops on the seed
    '{32'd655,        32'h0001_0000, 1'b1, 32'h0001_0000, 1'b1, 1'b0},
    '{32'd655,        32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd655,        32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd655,        32'h0000_0001, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd655,        32'h0004_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd655,        32'h0002_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd655,        32'h8000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd655,        32'h0000_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd655,        32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
    // zero tolerance: x = 0 drives the guess to zero, then the quotient saturates
    '{32'd0,          32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd0,          32'h0001_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd0,          32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd1,          32'h0000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'd1,          32'h0009_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{32'h0001_0000,  32'h0001_0000, 1'b1, 32'h0001_0000, 1'b1, 1'b0},
    // widest tolerance: every radicand stops on the seed
    '{32'hFFFF_FFFF,  32'h0000_0000, 1'b1, 32'h0001_0000, 1'b1, 1'b0},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'h0001_0000, 1'b1, 1'b0},
    '{32'hFFFF_FFFF,  32'h1234_5678, 1'b1, 32'h0001_0000, 1'b1, 1'b0}
  };

  // DUT-facing signals; the ones the bench drives are known from time zero.
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [WORD_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [WORD_W-1:0] radicand_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WORD_W-1:0] guess_o;
  logic              last_o;
  logic              hit_limit_o;

  // Bench state.
  logic [WORD_W-1:0] tol_q        = TOL_RESET;  // tolerance as the block holds it
  estimate_t         pending_estimates[$];      // estimates still owed, oldest first
  int unsigned       mismatches   = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       tx_idle_pct  = 7;
  int unsigned       rx_idle_pct  = 77;
  logic              hold_kick    = 1'b0;       // set by stimulus, seen by receiver
  logic              hold_done    = 1'b0;

  always #5 clk_i = ~clk_i;

  newton_square_root_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .radicand_i  (radicand_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .guess_o     (guess_o),
    .last_o      (last_o),
    .hit_limit_o (hit_limit_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // |g^2 - x| at 2*FRAC fraction bits, compared with the tolerance.
  function automatic logic err_below_tol(logic [WORD_W-1:0] g, logic [WORD_W-1:0] x);
    logic [63:0] sq, xs, ts, err;
    sq  = 64'(g) * 64'(g);
    xs  = 64'(x) << FRAC;
    ts  = 64'(tol_q) << FRAC;
    err = (sq >= xs) ? (sq - xs) : (xs - sq);
    return err < ts;
  endfunction

  // One Newton step; zero guess or oversized quotient saturates to all ones.
  function automatic logic [WORD_W-1:0] refine(logic [WORD_W-1:0] g, logic [WORD_W-1:0] x);
    logic [63:0] quo, sum;
    if (g == '0) begin
      quo = 64'(ALL_ONES);
    end else begin
      quo = (64'(x) << FRAC) / 64'(g);
      if (quo > 64'(ALL_ONES)) quo = 64'(ALL_ONES);
    end
    sum = quo + 64'(g);  // 33-bit sum, no wrap
    return sum[WORD_W:1];
  endfunction

  // Queue every estimate the block owes for radicand x.
  function automatic void predict_estimates(logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] g;
    int unsigned       steps;
    g     = ONE_Q;
    steps = 0;
    while (!err_below_tol(g, x) && steps < ITERS) begin
      pending_estimates.push_back('{guess: g, last: 1'b0, hit: 1'b0});
      g = refine(g, x);
      steps++;
    end
    pending_estimates.push_back('{guess: g, last: 1'b1, hit: !err_below_tol(g, x)});
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one radicand, with random idle gaps ahead of it, and wait for
  // acceptance. Handshake signals are sampled at the edge (pre-update values).
  task automatic offer(input logic [WORD_W-1:0] x, input logic known, input estimate_t typed);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    radicand_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    if (known) pending_estimates.push_back(typed);
    else predict_estimates(x);
  endtask

  // Stop offering and wait until every owed estimate has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Tolerance writes happen only with the block idle.
  task automatic set_tolerance(input logic [WORD_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tol_q = v;
  endtask

  // Mix of full-range, narrowed, small, near-perfect-square and corner radicands.
  function automatic logic [WORD_W-1:0] pick_radicand();
    logic [WORD_W-1:0] root;
    logic [63:0]       root_sq;
    case ($urandom_range(0, 5))
      0: return $urandom >> $urandom_range(0, 31);
      1: return $urandom_range(0, 32'h0003_0000);
      2: begin
        root    = $urandom_range(0, 32'h00FF_FFFF);
        root_sq = 64'(root) * 64'(root);
        return root_sq[FRAC +: WORD_W];
      end
      3: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return ALL_ONES;
          2: return ONE_Q;
          default: return 32'h8000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random back-pressure, plus one long hold on request so the
  // output register fills and the block stops taking radicands.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_kick && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each accepted estimate against the oldest owed one
  // ---------------------------------------------------------------------------
  task automatic report(input string field, input logic [WORD_W-1:0] want,
                        input logic [WORD_W-1:0] got);
    $display("%0t: %s expected %h actual %h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_estimates
    estimate_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_estimates.size() == 0) begin
        report("unexpected item, guess", '0, guess_o);
      end else begin
        want = pending_estimates.pop_front();
        if (guess_o !== want.guess)   report("guess", want.guess, guess_o);
        if (last_o !== want.last)     report("last", 32'(want.last), 32'(last_o));
        if (hit_limit_o !== want.hit) report("hit_limit", 32'(want.hit), 32'(hit_limit_o));
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    estimate_t         no_typed;
    estimate_t         typed;
    logic [WORD_W-1:0] tol;
    int unsigned       count;
    no_typed = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; first rows run under the reset tolerance.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].tol != tol_q) set_tolerance(DIRECTED[i].tol);
      typed = '{guess: DIRECTED[i].guess, last: DIRECTED[i].last, hit: DIRECTED[i].hit};
      offer(DIRECTED[i].radicand, DIRECTED[i].known, typed);
    end

    // Random part: three idle profiles, each swept over several tolerances.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 7;  rx_idle_pct = 77; end
        1: begin tx_idle_pct = 77; rx_idle_pct = 7;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < 5; chunk++) begin
        case (chunk)
          0: begin tol = TOL_RESET;                       count = 40; end
          1: begin tol = $urandom_range(1, 32'h0000_4000); count = 40; end
          2: begin tol = '0;                              count = 10; end  // always capped
          3: begin tol = $urandom;                        count = 15; end
          default: begin tol = ALL_ONES;                  count = 15; end
        endcase
        set_tolerance(tol);
        // long receiver hold while the sender keeps offering, no idling
        if (phase == 2 && chunk == 0) hold_kick = 1'b1;
        for (int k = 0; k < count; k++) begin
          // sender pause mid-stream until everything owed is back
          if (chunk == 1 && k == count / 2) drain();
          offer(pick_radicand(), 1'b0, no_typed);
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_estimates.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
